// ===== rtl/core/tccs_pkg.sv =====
// Shared types, codes and the microcode store of the text console.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam logic [1:0] REQ_PRINT = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Microcode addresses
    typedef enum logic [3:0] {
        S_RESET_FILL,
        S_IDLE,
        S_PUT,
        S_NEWLINE,
        S_RETURN,
        S_BKSP,
        S_READ,
        S_CLR_INIT,
        S_CLR_FILL,
        S_SCR_INIT,
        S_SCR_COPY,
        S_SCR_BLANK,
        S_FINISH
    } step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_RST_FILL,
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BKSP,
        OP_READ,
        OP_CLR_INIT,
        OP_FILL,
        OP_SCR_INIT,
        OP_SCR_COPY,
        OP_RESULT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_DISPATCH,
        CND_SWEEP_END,
        CND_COPY_END,
        CND_LAST_CELL,
        CND_LAST_ROW,
        CND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp_true;
        step_t jmp_false;
    } ucode_t;

    function automatic ucode_t ucode(input step_t step);
        ucode_t uw;
        unique case (step)
            S_RESET_FILL: uw = '{OP_RST_FILL, CND_SWEEP_END, S_IDLE,      S_RESET_FILL};
            S_IDLE:       uw = '{OP_NOP,      CND_DISPATCH,  S_IDLE,      S_IDLE};
            S_PUT:        uw = '{OP_PUT,      CND_LAST_CELL, S_SCR_INIT,  S_FINISH};
            S_NEWLINE:    uw = '{OP_NEWLINE,  CND_LAST_ROW,  S_SCR_INIT,  S_FINISH};
            S_RETURN:     uw = '{OP_RETURN,   CND_ALWAYS,    S_FINISH,    S_FINISH};
            S_BKSP:       uw = '{OP_BKSP,     CND_ALWAYS,    S_FINISH,    S_FINISH};
            S_READ:       uw = '{OP_READ,     CND_ALWAYS,    S_FINISH,    S_FINISH};
            S_CLR_INIT:   uw = '{OP_CLR_INIT, CND_ALWAYS,    S_CLR_FILL,  S_CLR_FILL};
            S_CLR_FILL:   uw = '{OP_FILL,     CND_SWEEP_END, S_FINISH,    S_CLR_FILL};
            S_SCR_INIT:   uw = '{OP_SCR_INIT, CND_ALWAYS,    S_SCR_COPY,  S_SCR_COPY};
            S_SCR_COPY:   uw = '{OP_SCR_COPY, CND_COPY_END,  S_SCR_BLANK, S_SCR_COPY};
            S_SCR_BLANK:  uw = '{OP_FILL,     CND_SWEEP_END, S_FINISH,    S_SCR_BLANK};
            S_FINISH:     uw = '{OP_RESULT,   CND_OUT_FREE,  S_IDLE,      S_FINISH};
            default:      uw = '{OP_NOP,      CND_ALWAYS,    S_IDLE,      S_IDLE};
        endcase
        return uw;
    endfunction

    // Entry point of the routine for one request
    function automatic step_t dispatch(input logic [1:0] req, input logic [7:0] ch);
        step_t s;
        unique case (req)
            REQ_PRINT:
            begin
                unique case (ch)
                    CH_NEWLINE:   s = S_NEWLINE;
                    CH_RETURN:    s = S_RETURN;
                    CH_BACKSPACE: s = S_BKSP;
                    default:      s = S_PUT;
                endcase
            end
            REQ_CLEAR: s = S_CLR_INIT;
            REQ_READ:  s = S_READ;
            default:   s = S_FINISH;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Text console top level: microcode sequencer, cursor datapath and screen store.
`timescale 1ns / 1ps

// Character-cell text console of ROWS x COLUMNS 16-bit cells (attribute byte high, character
// low) in a single-write, single-read memory with registered read data. A request is taken
// only while the sequencer sits in its idle step. A printable character, newline, return,
// backspace or cell read runs its operation step and then the result step, which loads the
// output register once that is free; an unused request type goes straight to the result step.
// Clear walks the store one cell a cycle, and a print that runs off the bottom row adds a
// scroll (one row-up copy per cycle, then blanking the bottom row) before the result step.
// The memory's one write per cycle sets the pace of these sweeps. After reset a clearing pass
// over all ROWS*COLUMNS cells (2000 by default) fills the store with blanks before the first
// request is taken; register writes are taken throughout. A result is held in an output
// register, so the next request may be taken while it waits.
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    char_code,
    input  logic [4:0]                    read_row,
    input  logic [6:0]                    read_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4:0]                    cursor_row,
    output logic [6:0]                    cursor_col,
    output logic [10:0]                   cursor_pos,
    output logic [15:0]                   read_data,
    output logic                          did_scroll
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int BASE_W = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [BASE_W-1:0] LAST_BASE = BASE_W'((ROWS - 1) * COLUMNS);

    logic [15:0] cells_mem [CELLS];

    tccs_pkg::step_t   pc_reg, pc_next;
    tccs_pkg::ucode_t  uw;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [7:0]        attr_reg, attr_next;
    logic              out_valid_reg, out_valid_next;

    logic [7:0]        ch_reg;
    logic [4:0]        rd_row_reg;
    logic [6:0]        rd_col_reg;
    logic              rd_ok_reg;
    logic              scroll_reg, scroll_next;
    logic [15:0]       rdata_reg;

    logic [4:0]        cursor_row_reg;
    logic [6:0]        cursor_col_reg;
    logic [10:0]       cursor_pos_reg;
    logic [15:0]       read_data_reg;
    logic              did_scroll_reg;

    logic              in_xfer;
    logic              out_free;
    logic              load_out;
    logic              cond_hit;
    logic              rd_in_range;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;
    logic [15:0]       blank;
    logic [31:0]       cur_lin;
    logic [31:0]       bk_lin;
    logic [31:0]       rd_lin;
    logic [31:0]       copy_lin;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;

    assign in_ready  = (pc_reg == tccs_pkg::S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign uw        = tccs_pkg::ucode(pc_reg);
    assign blank     = {attr_reg, tccs_pkg::CH_SPACE};

    assign cur_lin   = 32'(base_reg) + 32'(col_reg);
    assign bk_lin    = cur_lin - 32'd1;
    assign rd_lin    = 32'(rd_row_reg) * 32'(COLUMNS) + 32'(rd_col_reg);
    assign copy_lin  = 32'(addr_reg) + 32'(COLUMNS) + 32'd1;
    assign row_ext   = 32'(row_reg);
    assign col_ext   = 32'(col_reg);

    assign rd_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

    // Register port
    assign pready = 1'b1;
    assign prdata = 32'(attr_reg);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready)
        begin
            attr_next = pwdata[7:0];
        end
    end

    // Datapath driven by the current control word
    always_comb
    begin
        addr_next      = addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        scroll_next    = in_xfer ? 1'b0 : scroll_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        load_out       = 1'b0;

        unique case (uw.op)
            tccs_pkg::OP_NOP:
            begin
            end
            tccs_pkg::OP_RST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = {tccs_pkg::ATTR_RESET, tccs_pkg::CH_SPACE};
                addr_next = addr_reg + ADDR_W'(1);
            end
            tccs_pkg::OP_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_lin[ADDR_W-1:0];
                mem_wdata = {attr_reg, ch_reg};
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next  = '0;
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + BASE_W'(COLUMNS);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            tccs_pkg::OP_NEWLINE:
            begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                base_next = base_reg + BASE_W'(COLUMNS);
            end
            tccs_pkg::OP_RETURN:
            begin
                col_next = '0;
            end
            tccs_pkg::OP_BKSP:
            begin
                // at the left margin backspace does nothing
                if (col_reg != '0)
                begin
                    col_next  = col_reg - COL_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = bk_lin[ADDR_W-1:0];
                    mem_wdata = blank;
                end
            end
            tccs_pkg::OP_READ:
            begin
                mem_re    = rd_ok_reg;
                mem_raddr = rd_lin[ADDR_W-1:0];
            end
            tccs_pkg::OP_CLR_INIT:
            begin
                addr_next = '0;
                row_next  = '0;
                col_next  = '0;
                base_next = '0;
            end
            tccs_pkg::OP_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = blank;
                addr_next = addr_reg + ADDR_W'(1);
            end
            tccs_pkg::OP_SCR_INIT:
            begin
                // prime the copy with the first cell of the second row
                mem_re      = 1'b1;
                mem_raddr   = ADDR_W'(COLUMNS);
                addr_next   = '0;
                row_next    = ROW_W'(ROWS - 1);
                col_next    = '0;
                base_next   = LAST_BASE;
                scroll_next = 1'b1;
            end
            tccs_pkg::OP_SCR_COPY:
            begin
                // write the cell read last cycle one row up, fetch the next
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = rdata_reg;
                mem_re    = (copy_lin < 32'(CELLS));
                mem_raddr = copy_lin[ADDR_W-1:0];
                addr_next = addr_reg + ADDR_W'(1);
            end
            tccs_pkg::OP_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        unique case (uw.cond)
            tccs_pkg::CND_ALWAYS:    cond_hit = 1'b1;
            tccs_pkg::CND_DISPATCH:  cond_hit = in_xfer;
            tccs_pkg::CND_SWEEP_END: cond_hit = (addr_reg == ADDR_W'(CELLS - 1));
            tccs_pkg::CND_COPY_END:  cond_hit = (addr_reg == ADDR_W'(CELLS - COLUMNS - 1));
            tccs_pkg::CND_LAST_CELL: cond_hit = (col_reg == COL_W'(COLUMNS - 1)) &&
                                                (row_reg == ROW_W'(ROWS - 1));
            tccs_pkg::CND_LAST_ROW:  cond_hit = (row_reg == ROW_W'(ROWS - 1));
            tccs_pkg::CND_OUT_FREE:  cond_hit = out_free;
            default:                 cond_hit = 1'b1;
        endcase

        if (!cond_hit)
        begin
            pc_next = uw.jmp_false;
        end
        else if (uw.cond == tccs_pkg::CND_DISPATCH)
        begin
            pc_next = tccs_pkg::dispatch(req_type, char_code);
        end
        else
        begin
            pc_next = uw.jmp_true;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= tccs_pkg::S_RESET_FILL;
            addr_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            attr_reg      <= tccs_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            addr_reg      <= addr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request fields and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg     <= char_code;
            rd_row_reg <= read_row;
            rd_col_reg <= read_col;
            rd_ok_reg  <= (req_type == tccs_pkg::REQ_READ) && rd_in_range;
        end
        scroll_reg <= scroll_next;
        if (load_out)
        begin
            cursor_row_reg <= row_ext[4:0];
            cursor_col_reg <= col_ext[6:0];
            cursor_pos_reg <= cur_lin[10:0];
            read_data_reg  <= rd_ok_reg ? rdata_reg : 16'd0;
            did_scroll_reg <= scroll_reg;
        end
    end

    // Screen store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= cells_mem[mem_raddr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_pos = cursor_pos_reg;
    assign read_data  = read_data_reg;
    assign did_scroll = did_scroll_reg;

endmodule

// ===== rtl/core/tccs_checker.sv =====
// Port-level checks on the text console, bound to the top level.
`timescale 1ns / 1ps

module tccs_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic [10:0] cursor_pos,
    input logic [15:0] read_data,
    input logic        did_scroll
);

    localparam bit FITS = (ROWS <= 32) && (COLUMNS <= 128);

    logic [31:0] pos_calc;

    assign pos_calc = 32'(cursor_row) * 32'(COLUMNS) + 32'(cursor_col);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_pos) && $stable(read_data))
        else $error("result changed while stalled");

    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |-> pos_calc[10:0] == cursor_pos)
        else $error("linear position disagrees with row and column");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |-> 32'(cursor_col) < 32'(COLUMNS) && 32'(cursor_row) < 32'(ROWS))
        else $error("cursor outside the screen");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && did_scroll && FITS |->
            32'(cursor_row) == 32'(ROWS - 1) && cursor_col == 7'd0 && read_data == 16'd0)
        else $error("scroll left the cursor off the bottom row start");

endmodule

bind text_console_cursor_scroll tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cursor_pos (cursor_pos),
    .read_data  (read_data),
    .did_scroll (did_scroll)
);
